// ===== hw/rtl/bgd_pkg.sv =====
// Shared types, codes and reset values of the button gesture decoder.
package bgd_pkg;

    localparam int TIMER_BITS_DEF = 12;
    localparam int TALLY_MAX = 15;

    localparam logic [7:0]  CLICK_GAP_RST  = 8'd15;
    localparam logic [11:0] LONG_PRESS_RST = 12'd300;
    localparam logic [7:0]  HEAD_HOLD_RST  = 8'd45;
    localparam logic [9:0]  HEAD_FAST_RST  = 10'd132;

    localparam logic [1:0] REG_CLICK_GAP  = 2'd0;
    localparam logic [1:0] REG_LONG_PRESS = 2'd1;
    localparam logic [1:0] REG_HEAD_HOLD  = 2'd2;
    localparam logic [1:0] REG_HEAD_FAST  = 2'd3;

    localparam logic [2:0] ACT_NONE         = 3'd0;
    localparam logic [2:0] ACT_STAND_UP     = 3'd1;
    localparam logic [2:0] ACT_HEAD_TOGGLE  = 3'd2;
    localparam logic [2:0] ACT_BODY_TOGGLE  = 3'd3;
    localparam logic [2:0] ACT_RESTART_SYS  = 3'd4;
    localparam logic [2:0] ACT_KILL         = 3'd5;
    localparam logic [2:0] ACT_RESTART_LINK = 3'd6;

    localparam logic [1:0] HEAD_NONE = 2'd0;
    localparam logic [1:0] HEAD_SIT  = 2'd1;
    localparam logic [1:0] HEAD_KILL = 2'd2;

    localparam int FLAG_LIMP  = 0;
    localparam int FLAG_STAND = 1;
    localparam int FLAG_SIT   = 2;
    localparam int FLAG_HLIMP = 3;

    typedef struct packed {
        logic [7:0]  click_gap_ticks;
        logic [11:0] long_press_ticks;
        logic [7:0]  head_hold_ticks;
        logic [9:0]  head_fast_limit;
    } bgd_cfg_t;

    typedef struct packed {
        logic chest_pressed;
        logic head_rear;
        logic head_middle;
        logic head_front;
        logic left_foot_bumper;
        logic right_foot_bumper;
        logic is_falling;
    } bgd_in_t;

    typedef struct packed {
        logic [3:0] press_tally;
        logic       long_press_spent;
        logic [7:0] rear_pad_timer;
        logic [7:0] middle_pad_timer;
        logic [7:0] front_pad_timer;
        logic [3:0] mode_flags;
        logic       kill_latched;
    } bgd_state_t;

    typedef struct packed {
        logic [2:0] click_action;
        logic [3:0] click_count;
        logic       shutdown_request;
        logic [1:0] head_action;
        logic       limp_mode;
        logic       standing_mode;
        logic       sit_unstiff_mode;
        logic       head_limp_mode;
    } bgd_res_t;

endpackage

// ===== hw/rtl/button_gesture_decoder.sv =====
// Top level of the button gesture decoder: stream ports, registers and state.
//
// The block takes one tick of button levels per request and returns one result per
// request, in the cycle after acceptance, through an output register. A new
// request is accepted in every cycle while the result register is empty or its
// content is being taken in the same cycle, so the sustained rate is one tick per
// clock; the whole update of counters, pad timers and mode flags is one pass of
// combinational logic between the state registers and the result register. Users
// must write configuration via the APB port with no request in flight; unenforced.
module button_gesture_decoder
    import bgd_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // Fields from bit 0: chest_pressed, head_rear, head_middle, head_front,
    // left_foot_bumper, right_foot_bumper, is_falling, one zero pad bit.
    input  logic [7:0]  s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // Fields from bit 0: click_action[2:0], click_count[6:3], shutdown_request[7],
    // head_action[9:8], limp_mode[10], standing_mode[11], sit_unstiff_mode[12],
    // head_limp_mode[13], two zero pad bits.
    output logic [15:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    bgd_cfg_t              cfg_reg;
    bgd_state_t            st_reg;
    bgd_state_t            st_next;
    logic [TIMER_BITS-1:0] release_reg;
    logic [TIMER_BITS-1:0] release_next;
    logic [TIMER_BITS-1:0] hold_reg;
    logic [TIMER_BITS-1:0] hold_next;
    bgd_res_t              res_reg;
    bgd_res_t              res_next;
    logic                  valid_reg;
    bgd_in_t               in_item;
    logic                  accept;
    logic                  cfg_write;

    assign in_item.chest_pressed     = s_tdata[0];
    assign in_item.head_rear         = s_tdata[1];
    assign in_item.head_middle       = s_tdata[2];
    assign in_item.head_front        = s_tdata[3];
    assign in_item.left_foot_bumper  = s_tdata[4];
    assign in_item.right_foot_bumper = s_tdata[5];
    assign in_item.is_falling        = s_tdata[6];

    assign s_tready  = !valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    bgd_step #(
        .TIMER_BITS(TIMER_BITS)
    ) u_step (
        .cfg_i     (cfg_reg),
        .in_i      (in_item),
        .st_i      (st_reg),
        .release_i (release_reg),
        .hold_i    (hold_reg),
        .st_o      (st_next),
        .release_o (release_next),
        .hold_o    (hold_next),
        .res_o     (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.click_gap_ticks  <= CLICK_GAP_RST;
            cfg_reg.long_press_ticks <= LONG_PRESS_RST;
            cfg_reg.head_hold_ticks  <= HEAD_HOLD_RST;
            cfg_reg.head_fast_limit  <= HEAD_FAST_RST;
            st_reg      <= '0;
            release_reg <= '0;
            hold_reg    <= '0;
            valid_reg   <= 1'b0;
        end else begin
            if (cfg_write) begin
                case (paddr[3:2])
                    REG_CLICK_GAP:  cfg_reg.click_gap_ticks  <= pwdata[7:0];
                    REG_LONG_PRESS: cfg_reg.long_press_ticks <= pwdata[11:0];
                    REG_HEAD_HOLD:  cfg_reg.head_hold_ticks  <= pwdata[7:0];
                    REG_HEAD_FAST:  cfg_reg.head_fast_limit  <= pwdata[9:0];
                    default: begin
                    end
                endcase
            end
            if (accept) begin
                st_reg      <= st_next;
                release_reg <= release_next;
                hold_reg    <= hold_next;
                valid_reg   <= 1'b1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            res_reg <= res_next;
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_CLICK_GAP:  prdata = {24'd0, cfg_reg.click_gap_ticks};
            REG_LONG_PRESS: prdata = {20'd0, cfg_reg.long_press_ticks};
            REG_HEAD_HOLD:  prdata = {24'd0, cfg_reg.head_hold_ticks};
            REG_HEAD_FAST:  prdata = {22'd0, cfg_reg.head_fast_limit};
            default:        prdata = '0;
        endcase
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {2'b00,
                       res_reg.head_limp_mode,
                       res_reg.sit_unstiff_mode,
                       res_reg.standing_mode,
                       res_reg.limp_mode,
                       res_reg.head_action,
                       res_reg.shutdown_request,
                       res_reg.click_count,
                       res_reg.click_action};

endmodule

// ===== hw/rtl/bgd_step.sv =====
// Next-state and result logic for one tick of button levels.
module bgd_step
    import bgd_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
) (
    input  bgd_cfg_t              cfg_i,
    input  bgd_in_t               in_i,
    input  bgd_state_t            st_i,
    input  logic [TIMER_BITS-1:0] release_i,
    input  logic [TIMER_BITS-1:0] hold_i,
    output bgd_state_t            st_o,
    output logic [TIMER_BITS-1:0] release_o,
    output logic [TIMER_BITS-1:0] hold_o,
    output bgd_res_t              res_o
);

    localparam int CMP_W = (TIMER_BITS > 12) ? TIMER_BITS : 12;

    bgd_state_t            st;
    logic [TIMER_BITS-1:0] rel;
    logic [TIMER_BITS-1:0] hold;
    logic [2:0]            action;
    logic [3:0]            count;
    logic                  shutdown;
    logic [1:0]            head_act;
    logic                  bumper;
    logic [9:0]            total;

    always_comb begin
        st       = st_i;
        rel      = release_i;
        hold     = hold_i;
        action   = ACT_NONE;
        count    = '0;
        shutdown = 1'b0;
        head_act = HEAD_NONE;
        bumper   = in_i.left_foot_bumper | in_i.right_foot_bumper;
        total    = '0;

        if (rel > TIMER_BITS'(cfg_i.click_gap_ticks) && st.press_tally != '0) begin
            count          = st.press_tally;
            st.press_tally = '0;
            case (count)
                4'd1: begin
                    if (st.mode_flags[FLAG_SIT]) begin
                        st.mode_flags[FLAG_SIT]   = 1'b0;
                        st.mode_flags[FLAG_LIMP]  = 1'b0;
                        st.mode_flags[FLAG_STAND] = 1'b1;
                        action = ACT_STAND_UP;
                    end
                end
                4'd2: begin
                    if (bumper) begin
                        if (!in_i.is_falling) begin
                            st.mode_flags[FLAG_HLIMP] = ~st.mode_flags[FLAG_HLIMP];
                            action = ACT_HEAD_TOGGLE;
                        end
                    end else if (st.mode_flags[FLAG_LIMP]) begin
                        st.mode_flags[FLAG_LIMP]  = 1'b0;
                        st.mode_flags[FLAG_STAND] = 1'b1;
                        action = ACT_BODY_TOGGLE;
                    end else if (!in_i.is_falling) begin
                        st.mode_flags[FLAG_LIMP]  = 1'b1;
                        st.mode_flags[FLAG_STAND] = 1'b0;
                        action = ACT_BODY_TOGGLE;
                    end
                end
                4'd3: begin
                    if (bumper) begin
                        action = ACT_RESTART_SYS;
                    end else if (!in_i.is_falling && !st.kill_latched) begin
                        st.kill_latched = 1'b1;
                        action = ACT_KILL;
                    end
                end
                4'd4: begin
                    if (!in_i.is_falling) begin
                        action = ACT_RESTART_LINK;
                    end
                end
                default: begin
                    action = ACT_NONE;
                end
            endcase
        end

        if (!st.long_press_spent && CMP_W'(hold) > CMP_W'(cfg_i.long_press_ticks)) begin
            shutdown                 = 1'b1;
            st.mode_flags[FLAG_LIMP] = 1'b1;
            st.long_press_spent      = 1'b1;
            hold                     = '0;
        end

        if (in_i.chest_pressed) begin
            if (!st.long_press_spent && !(&hold)) begin
                hold = hold + 1'b1;
            end
            rel = '0;
        end else begin
            if (!(&rel)) begin
                rel = rel + 1'b1;
            end
            if (!st.long_press_spent && hold != '0) begin
                if (st.press_tally != 4'(TALLY_MAX)) begin
                    st.press_tally = st.press_tally + 1'b1;
                end
                hold = '0;
            end
        end

        if (in_i.head_rear) begin
            st.rear_pad_timer = cfg_i.head_hold_ticks;
        end else if (st.rear_pad_timer != '0) begin
            st.rear_pad_timer = st.rear_pad_timer - 1'b1;
        end
        if (in_i.head_middle) begin
            st.middle_pad_timer = cfg_i.head_hold_ticks;
        end else if (st.middle_pad_timer != '0) begin
            st.middle_pad_timer = st.middle_pad_timer - 1'b1;
        end
        if (in_i.head_front) begin
            st.front_pad_timer = cfg_i.head_hold_ticks;
        end else if (st.front_pad_timer != '0) begin
            st.front_pad_timer = st.front_pad_timer - 1'b1;
        end

        if (st.rear_pad_timer != '0 && st.middle_pad_timer != '0 &&
            st.front_pad_timer != '0 && !in_i.is_falling) begin
            total = 10'(st.rear_pad_timer) + 10'(st.middle_pad_timer)
                  + 10'(st.front_pad_timer);
            st.rear_pad_timer   = '0;
            st.middle_pad_timer = '0;
            st.front_pad_timer  = '0;
            if (total > cfg_i.head_fast_limit) begin
                st.mode_flags[FLAG_SIT] = 1'b1;
                head_act = HEAD_SIT;
            end else if (!st.kill_latched) begin
                st.kill_latched = 1'b1;
                head_act = HEAD_KILL;
            end
        end

        st_o      = st;
        release_o = rel;
        hold_o    = hold;

        res_o.click_action     = action;
        res_o.click_count      = count;
        res_o.shutdown_request = shutdown;
        res_o.head_action      = head_act;
        res_o.limp_mode        = st.mode_flags[FLAG_LIMP];
        res_o.standing_mode    = st.mode_flags[FLAG_STAND];
        res_o.sit_unstiff_mode = st.mode_flags[FLAG_SIT];
        res_o.head_limp_mode   = st.mode_flags[FLAG_HLIMP];
    end

endmodule
